FILE: sv/dsatur_graph_coloring_top_defines.svh
// ----------------------------------------------------------------------------
// DSATUR coloring assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DSATUR_GRAPH_COLORING_TOP_DEFINES_SVH
`define DSATUR_GRAPH_COLORING_TOP_DEFINES_SVH

// condition holds at every edge
`define DSG_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define DSG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DSG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/dsg_pkg.sv
// ----------------------------------------------------------------------------
// DSATUR coloring package
// Sequencer states, opcodes, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package dsg_pkg;

   localparam int ROW_WIDTH = 64;

   localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;

   localparam logic [0:0] OP_LOAD = 1'b0;
   localparam logic [0:0] OP_RUN  = 1'b1;

   localparam logic [1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [1:0] CSR_COLOR_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_RANDOM_SEED  = 2'd2;

   localparam logic [6:0]  VERTEX_COUNT_RST = 7'd64;
   localparam logic [5:0]  COLOR_LIMIT_RST  = 6'd4;
   localparam logic [31:0] RANDOM_SEED_RST  = 32'd1;

   localparam logic [6:0] COLOR_NONE = 7'h7F;   // -1 in 7 bits

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEG_RD,
      ST_DEG_CNT,
      ST_COMMIT,
      ST_STEP_RD,
      ST_STEP_LD,
      ST_SCAN_RD,
      ST_SCAN_UPD,
      ST_CAND_RD,
      ST_CAND_SCAN,
      ST_LFSR,
      ST_MOD,
      ST_CONF_RD,
      ST_CONF_CHK,
      ST_OUT_RD,
      ST_OUT_SEND
   } state_type;

endpackage

FILE: sv/dsatur_graph_coloring_top.sv
// ----------------------------------------------------------------------------
// DSATUR greedy graph coloring
// Loads adjacency rows, then colors the graph in DSATUR order with k colors.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: a word with tuser = load carries row_index and row_bits and
//    is stored; a word with tuser = run starts a coloring pass.
//  rsp channel: after a run, one word per vertex 0..n-1 in index order; the
//    final word has tlast and carries the conflict edge and vertex totals.
//  csr port: vertex_count, color_limit, random_seed, written only while idle.
// Sequence:
//  load: the row is written straight from the request word. run: degree
//    counting (one row read plus eight byte steps per row), then per colored
//    vertex a commit, a neighbor scan, a free-color search and, when no color
//    is free, an LFSR step, a 32-step remainder and a conflict walk.
//  results: each is a color memory read, then the held output word.
// The block takes no request while a run or its results are in flight.
// Reset: synchronous, clears the sequencer and loads register defaults;
//  adjacency rows are undefined until loaded. Per-run state is cleared by
//  valid bits at the start of every run, so no clearing sweep is needed.
// A stalled rsp_tready holds the current result word unchanged.
// ----------------------------------------------------------------------------
`include "dsatur_graph_coloring_top_defines.svh"

module dsatur_graph_coloring_top
   import dsg_pkg::*;
#(
   parameter int MAX_VERTICES    = 64,
   parameter int COLOR_LIMIT_MAX = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [5:0] row_index, [69:6] row_bits, zero pad
   input  logic [0:0]  req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [5:0] vertex, [12:6] color,
                                    // [25:13] conflict_edges,
                                    // [32:26] conflict_vertices, zero pad
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int ROW_CAP = (MAX_VERTICES < ROW_WIDTH) ? MAX_VERTICES : ROW_WIDTH;
   localparam int CW      = $clog2(ROW_CAP + 1);
   localparam int VW      = $clog2(ROW_CAP);
   localparam int KW      = $clog2(COLOR_LIMIT_MAX + 1);

   typedef struct packed {
      logic [KW-1:0]              sat;
      logic [COLOR_LIMIT_MAX-1:0] seen;
   } nbr_type;

   // configuration
   logic [6:0]  vcount_ff;
   logic [5:0]  climit_ff;
   logic [31:0] seed_ff;

   // sequencer and datapath registers
   state_type state_ff, state_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [2:0]         byte_ff, byte_in;
   logic [CW-1:0]      acc_ff, acc_in;
   logic [CW-1:0]      best_deg_ff, best_deg_in;
   logic [VW-1:0]      v_ff, v_in;
   logic [KW-1:0]      color_ff, color_in;
   logic [CW-1:0]      ccnt_ff, ccnt_in;
   logic [63:0]        rowv_ff, rowv_in;
   logic [VW-1:0]      sel_ff, sel_in;
   logic               sel_vld_ff, sel_vld_in;
   logic [KW-1:0]      best_sat_ff, best_sat_in;
   logic [KW-1:0]      cand_ff, cand_in;
   logic [31:0]        lfsr_ff, lfsr_in;
   logic [KW:0]        rem_ff, rem_in;
   logic [4:0]         bit_ff, bit_in;
   logic [CW:0]        checked_ff, checked_in;
   logic [12:0]        edges_ff, edges_in;
   logic [6:0]         verts_ff, verts_in;
   logic [ROW_CAP-1:0] marks_ff, marks_in;
   logic [ROW_CAP-1:0] colored_ff, colored_in;
   logic [ROW_CAP-1:0] nvld_ff, nvld_in;

   // memories
   logic [63:0]   adj_mem [ROW_CAP];
   logic [63:0]   adj_q;
   logic          adj_re, adj_we;
   logic [VW-1:0] adj_raddr, adj_waddr;

   nbr_type       nbr_mem [ROW_CAP];
   nbr_type       nbr_q, nbr_wdata;
   logic          nbr_vld_q;
   logic          nbr_re, nbr_we;
   logic [VW-1:0] nbr_raddr, nbr_waddr;

   logic [KW-1:0] vc_mem [ROW_CAP];
   logic [KW-1:0] vc_q, vc_wdata;
   logic          vc_re, vc_we;
   logic [VW-1:0] vc_raddr, vc_waddr;

   logic req_acc, rsp_acc, rsp_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT_SEND);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign rsp_last   = (i_ff == n_ff - 1'b1);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VERTEX_COUNT_RST;
         climit_ff <= COLOR_LIMIT_RST;
         seed_ff   <= RANDOM_SEED_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vcount_ff <= csr_wdata[6:0];
            CSR_COLOR_LIMIT:  climit_ff <= csr_wdata[5:0];
            CSR_RANDOM_SEED:  seed_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // memories: one write and one registered read port each
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adj_we) adj_mem[adj_waddr] <= req_tdata[69:6];
      if (adj_re) adj_q <= adj_mem[adj_raddr];
   end

   always_ff @(posedge clock) begin
      if (nbr_we) nbr_mem[nbr_waddr] <= nbr_wdata;
      if (nbr_re) begin
         nbr_q     <= nbr_mem[nbr_raddr];
         nbr_vld_q <= nvld_ff[nbr_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (vc_we) vc_mem[vc_waddr] <= vc_wdata;
      if (vc_re) vc_q <= vc_mem[vc_raddr];
   end

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   logic scan_found;
   logic conf_stop;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_acc && req_tuser == OP_RUN) state_in = ST_DEG_RD;
         ST_DEG_RD:    state_in = ST_DEG_CNT;
         ST_DEG_CNT:   if (byte_ff == 3'd7)
                          state_in = (i_ff + 1'b1 == n_ff) ? ST_COMMIT : ST_DEG_RD;
         ST_COMMIT:    state_in = (ccnt_ff + 1'b1 == n_ff) ? ST_OUT_RD : ST_STEP_RD;
         ST_STEP_RD:   state_in = ST_STEP_LD;
         ST_STEP_LD:   state_in = ST_SCAN_RD;
         ST_SCAN_RD:   state_in = ST_SCAN_UPD;
         ST_SCAN_UPD:  if (i_ff + 1'b1 == n_ff)
                          state_in = scan_found ? ST_CAND_RD : ST_OUT_RD;
                       else
                          state_in = ST_SCAN_RD;
         ST_CAND_RD:   state_in = ST_CAND_SCAN;
         ST_CAND_SCAN: begin
            if (!(cand_ff < k_ff && nbr_vld_q && nbr_q.seen[cand_ff]))
               state_in = (cand_ff < k_ff) ? ST_COMMIT : ST_LFSR;
         end
         ST_LFSR:      state_in = ST_MOD;
         ST_MOD:       if (bit_ff == 5'd0) state_in = ST_CONF_RD;
         ST_CONF_RD:   state_in = ST_CONF_CHK;
         ST_CONF_CHK:  if (i_ff + 1'b1 == n_ff)
                          state_in = conf_stop ? ST_OUT_RD : ST_COMMIT;
                       else
                          state_in = ST_CONF_RD;
         ST_OUT_RD:    state_in = ST_OUT_SEND;
         ST_OUT_SEND:  if (rsp_acc) state_in = rsp_last ? ST_IDLE : ST_OUT_RD;
         default:      state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // datapath and memory control
   // ------------------------------------------------------------------
   logic [3:0]                 pc;
   logic [COLOR_LIMIT_MAX-1:0] seen_cur;
   logic [KW-1:0]              sat_cur, sat_new;
   logic                       adj_hit, conf_hit;
   logic [KW:0]                rem_sh;
   logic [CW:0]                chk1, chkf;
   logic [31:0]                lfsr_nx;

   always_comb begin
      n_in = n_ff;  k_in = k_ff;  i_in = i_ff;  byte_in = byte_ff;
      acc_in = acc_ff;  best_deg_in = best_deg_ff;  v_in = v_ff;
      color_in = color_ff;  ccnt_in = ccnt_ff;  rowv_in = rowv_ff;
      sel_in = sel_ff;  sel_vld_in = sel_vld_ff;  best_sat_in = best_sat_ff;
      cand_in = cand_ff;  lfsr_in = lfsr_ff;  rem_in = rem_ff;  bit_in = bit_ff;
      checked_in = checked_ff;  edges_in = edges_ff;  verts_in = verts_ff;
      marks_in = marks_ff;  colored_in = colored_ff;  nvld_in = nvld_ff;

      adj_re = 1'b0;  adj_we = 1'b0;  adj_raddr = i_ff[VW-1:0];
      adj_waddr = req_tdata[VW-1:0];
      nbr_re = 1'b0;  nbr_we = 1'b0;  nbr_raddr = i_ff[VW-1:0];
      nbr_waddr = i_ff[VW-1:0];
      vc_re = 1'b0;   vc_we = 1'b0;   vc_raddr = i_ff[VW-1:0];
      vc_waddr = v_ff;  vc_wdata = color_ff;

      pc       = '0;
      seen_cur = nbr_vld_q ? nbr_q.seen : '0;
      sat_cur  = nbr_vld_q ? nbr_q.sat  : '0;
      adj_hit  = rowv_ff[i_ff[VW-1:0]];
      sat_new  = sat_cur;
      nbr_wdata.seen = seen_cur;
      nbr_wdata.sat  = sat_cur;
      scan_found = sel_vld_ff || !colored_ff[i_ff[VW-1:0]];
      conf_hit = adj_q[v_ff] && colored_ff[i_ff[VW-1:0]] && (vc_q == color_ff);
      chk1     = checked_ff + (CW+1)'(conf_hit);
      chkf     = (chk1 != '0) ? chk1 + 1'b1 : '0;
      conf_stop = (chkf == (CW+1)'(n_ff));
      rem_sh   = {rem_ff[KW-1:0], lfsr_ff[bit_ff]};
      if (rem_sh >= (KW+1)'(k_ff)) rem_sh = rem_sh - (KW+1)'(k_ff);
      lfsr_nx  = lfsr_ff[0] ? ({1'b0, lfsr_ff[31:1]} ^ LFSR_TAPS)
                            : {1'b0, lfsr_ff[31:1]};

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tuser == OP_LOAD) begin
               if (int'(req_tdata[5:0]) < ROW_CAP) adj_we = 1'b1;
            end else if (req_acc) begin
               if (vcount_ff == 7'd0) n_in = CW'(1);
               else if (int'(vcount_ff) > ROW_CAP) n_in = CW'(ROW_CAP);
               else n_in = CW'(vcount_ff);
               if (climit_ff == 6'd0) k_in = KW'(1);
               else if (int'(climit_ff) > COLOR_LIMIT_MAX) k_in = KW'(COLOR_LIMIT_MAX);
               else k_in = KW'(climit_ff);
               lfsr_in = seed_ff;
               i_in = '0;  best_deg_in = '0;  v_in = '0;  color_in = '0;
               ccnt_in = '0;  marks_in = '0;  colored_in = '0;  nvld_in = '0;
               edges_in = '0;  verts_in = '0;
            end
         end
         ST_DEG_RD: begin
            adj_re = 1'b1;
            byte_in = '0;
            acc_in = '0;
         end
         ST_DEG_CNT: begin
            // one byte of the row per cycle, bits at or above n masked
            for (int t = 0; t < 8; t++) begin
               if (int'({byte_ff, 3'(t)}) < int'(n_ff))
                  pc = pc + 4'(adj_q[{byte_ff, 3'(t)}]);
            end
            acc_in = acc_ff + CW'(pc);
            byte_in = byte_ff + 1'b1;
            if (byte_ff == 3'd7) begin
               if (acc_in > best_deg_ff) begin
                  best_deg_in = acc_in;
                  v_in = i_ff[VW-1:0];
               end
               i_in = i_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            vc_we = 1'b1;
            colored_in[v_ff] = 1'b1;
            ccnt_in = ccnt_ff + 1'b1;
            i_in = '0;
         end
         ST_STEP_RD: begin
            adj_re = 1'b1;
            adj_raddr = v_ff;
         end
         ST_STEP_LD: begin
            rowv_in = adj_q;
            i_in = '0;
            sel_vld_in = 1'b0;
            best_sat_in = '0;
         end
         ST_SCAN_RD: begin
            nbr_re = 1'b1;
         end
         ST_SCAN_UPD: begin
            if (adj_hit) begin
               if (!seen_cur[color_ff]) begin
                  nbr_wdata.seen[color_ff] = 1'b1;
                  sat_new = sat_cur + 1'b1;
               end
               nbr_wdata.sat = sat_new;
               nbr_we = 1'b1;
               nvld_in[i_ff[VW-1:0]] = 1'b1;
            end
            if (!colored_ff[i_ff[VW-1:0]] && (!sel_vld_ff || sat_new > best_sat_ff)) begin
               sel_in = i_ff[VW-1:0];
               sel_vld_in = 1'b1;
               best_sat_in = sat_new;
            end
            i_in = i_ff + 1'b1;
            if (i_ff + 1'b1 == n_ff) begin
               i_in = '0;
               v_in = sel_in;
            end
         end
         ST_CAND_RD: begin
            nbr_re = 1'b1;
            nbr_raddr = v_ff;
            cand_in = '0;
         end
         ST_CAND_SCAN: begin
            if (cand_ff < k_ff && nbr_vld_q && nbr_q.seen[cand_ff])
               cand_in = cand_ff + 1'b1;
            else if (cand_ff < k_ff)
               color_in = cand_ff;
         end
         ST_LFSR: begin
            lfsr_in = lfsr_nx;
            rem_in = '0;
            bit_in = 5'd31;
            i_in = '0;
            checked_in = '0;
         end
         ST_MOD: begin
            // restoring remainder, one dividend bit per cycle
            rem_in = rem_sh;
            bit_in = bit_ff - 1'b1;
            if (bit_ff == 5'd0) color_in = rem_sh[KW-1:0];
         end
         ST_CONF_RD: begin
            adj_re = 1'b1;
            vc_re = 1'b1;
         end
         ST_CONF_CHK: begin
            if (conf_hit) begin
               edges_in = edges_ff + 1'b1;
               if (!marks_ff[i_ff[VW-1:0]]) begin
                  marks_in[i_ff[VW-1:0]] = 1'b1;
                  verts_in = verts_in + 1'b1;
               end
            end
            checked_in = chk1;
            i_in = i_ff + 1'b1;
            if (i_ff + 1'b1 == n_ff) begin
               i_in = '0;
               if (chk1 != '0 && !marks_in[v_ff]) begin
                  marks_in[v_ff] = 1'b1;
                  verts_in = verts_in + 1'b1;
               end
            end
         end
         ST_OUT_RD: begin
            vc_re = 1'b1;
         end
         ST_OUT_SEND: begin
            if (rsp_acc) i_in = i_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         i_ff       <= '0;
         n_ff       <= CW'(1);
         k_ff       <= KW'(1);
         ccnt_ff    <= '0;
         sel_vld_ff <= 1'b0;
         marks_ff   <= '0;
         colored_ff <= '0;
         nvld_ff    <= '0;
         edges_ff   <= '0;
         verts_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         i_ff       <= i_in;
         n_ff       <= n_in;
         k_ff       <= k_in;
         ccnt_ff    <= ccnt_in;
         sel_vld_ff <= sel_vld_in;
         marks_ff   <= marks_in;
         colored_ff <= colored_in;
         nvld_ff    <= nvld_in;
         edges_ff   <= edges_in;
         verts_ff   <= verts_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      acc_ff      <= acc_in;
      best_deg_ff <= best_deg_in;
      v_ff        <= v_in;
      color_ff    <= color_in;
      rowv_ff     <= rowv_in;
      sel_ff      <= sel_in;
      best_sat_ff <= best_sat_in;
      cand_ff     <= cand_in;
      lfsr_ff     <= lfsr_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      checked_ff  <= checked_in;
   end

   // ------------------------------------------------------------------
   // result word
   // ------------------------------------------------------------------
   logic [6:0] out_color;
   assign out_color = colored_ff[i_ff[VW-1:0]] ? 7'(vc_q) : COLOR_NONE;
   assign rsp_tlast = rsp_last;
   assign rsp_tdata = {7'd0,
                       rsp_last ? verts_ff : 7'd0,
                       rsp_last ? edges_ff : 13'd0,
                       out_color,
                       6'(i_ff)};

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `DSG_ASSERT_ALWAYS(a_req_rsp_exclusive, !(req_tready && rsp_tvalid),
      "request taken while results pending")
   `DSG_ASSERT_IMPLIES(a_color_in_range, state_ff == ST_COMMIT, color_ff < k_ff,
      "committed color beyond limit")
   `DSG_ASSERT_NEXT(a_commit_sets_colored, state_ff == ST_COMMIT,
      colored_ff[$past(v_ff)], "committed vertex not marked colored")
   `DSG_ASSERT_ALWAYS(a_conf_verts_bound, verts_ff <= 7'(n_ff),
      "conflict vertex count exceeds vertex count")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DSATUR coloring testbench
// Loads random and hand-built graphs, runs colorings under several register
// settings with bursty requests and stalled results, and checks every color
// word against an in-bench DSATUR predictor.
// ----------------------------------------------------------------------------
module testbench;
   import dsg_pkg::*;

   localparam int NV = 64;
   localparam int NC = 63;

   typedef struct packed {
      logic [5:0]  vertex;
      logic [6:0]  color;
      logic [12:0] edges;
      logic [6:0]  verts;
      logic        last;
   } color_word_type;

   typedef struct {
      logic        op;
      logic [5:0]  row;
      logic [63:0] bits;
   } req_item_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   dsatur_graph_coloring_top dut (.*);

   always #5 clock = ~clock;

   // predictor copy of the block's state
   logic [63:0] adj_rows [NV];
   logic [6:0]  n_reg = 7'd64;
   logic [5:0]  k_reg = 6'd4;
   logic [31:0] seed_reg = 32'd1;

   color_word_type expected_colors [$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          done = 0;

   function automatic int clamp_n();
      int n = n_reg;
      if (n < 1) n = 1;
      if (n > NV) n = NV;
      return n;
   endfunction

   // DSATUR run: appends one expected word per vertex
   task automatic predict_coloring();
      int n, k, v, best, d, sel, colored, chk;
      int cnt [NV][NC+1];
      int vcol [NV];
      int cand [NV];
      logic [63:0] marks;
      logic [31:0] lfsr;
      logic        fb;
      int e_cnt, v_cnt, c;
      color_word_type w;
      n = clamp_n();
      k = (k_reg < 1) ? 1 : k_reg;
      for (int i = 0; i < NV; i++) begin
         vcol[i] = -1; cand[i] = 0;
         for (int j = 0; j <= NC; j++) cnt[i][j] = 0;
      end
      marks = '0; e_cnt = 0; v_cnt = 0; lfsr = seed_reg;
      v = 0; best = 0;
      for (int i = 0; i < n; i++) begin
         d = 0;
         for (int j = 0; j < n; j++) d += adj_rows[i][j];
         if (d > best) begin best = d; v = i; end
      end
      c = 0; vcol[v] = 0; colored = 1;
      while (colored < n) begin
         sel = -1;
         for (int i = 0; i < n; i++) begin
            if (adj_rows[v][i]) begin
               if (cnt[i][c] == 0) cnt[i][k]++;
               cnt[i][c]++;
               if (vcol[i] < 0) begin
                  int f = 0;
                  while (f < k && cnt[i][f] != 0) f++;
                  cand[i] = f;
               end
            end
            if (vcol[i] < 0) begin
               if (sel < 0) sel = i;
               else if (cnt[i][k] > cnt[sel][k]) sel = i;
            end
         end
         if (sel < 0) break;
         v = sel; c = cand[v];
         if (c >= k) begin
            // Galois step, then remainder mod k
            fb = lfsr[0];
            lfsr = lfsr >> 1;
            if (fb) lfsr ^= LFSR_TAPS;
            c = lfsr % k;
            chk = 0;
            for (int i = 0; i < n; i++)
               if (adj_rows[i][v] && vcol[i] == c) begin
                  e_cnt++; chk++;
                  if (!marks[i]) begin marks[i] = 1; v_cnt++; end
               end
            if (chk != 0) begin
               chk++;
               if (!marks[v]) begin marks[v] = 1; v_cnt++; end
            end
            if (chk == n) break;  // early stop: everything conflicts
         end
         vcol[v] = c; colored++;
      end
      for (int i = 0; i < n; i++) begin
         w.vertex = i[5:0];
         w.color  = vcol[i][6:0];
         w.last   = (i == n - 1);
         w.edges  = w.last ? e_cnt[12:0] : '0;
         w.verts  = w.last ? v_cnt[6:0] : '0;
         expected_colors.push_back(w);
      end
   endtask

   // result side: random stall pattern, checker, watchdog
   int stall_mode = 0;
   always @(posedge clock) begin
      color_word_type got, exp_w;
      if (!reset) begin
         if (($urandom & 63) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            2: rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.vertex = rsp_tdata[5:0];
            got.color  = rsp_tdata[12:6];
            got.edges  = rsp_tdata[25:13];
            got.verts  = rsp_tdata[32:26];
            got.last   = rsp_tlast;
            if (expected_colors.size() == 0) begin
               $error("unexpected color word vertex %0d", got.vertex);
               errors++;
            end else begin
               exp_w = expected_colors.pop_front();
               if (got.vertex !== exp_w.vertex) begin
                  $error("vertex exp %0d got %0d", exp_w.vertex, got.vertex); errors++;
               end
               if (got.color !== exp_w.color) begin
                  $error("color exp %0d got %0d", $signed(exp_w.color),
                         $signed(got.color));
                  errors++;
               end
               if (got.edges !== exp_w.edges) begin
                  $error("conflict_edges exp %0d got %0d", exp_w.edges, got.edges);
                  errors++;
               end
               if (got.verts !== exp_w.verts) begin
                  $error("conflict_vertices exp %0d got %0d", exp_w.verts, got.verts);
                  errors++;
               end
               if (got.last !== exp_w.last) begin
                  $error("last exp %0d got %0d", exp_w.last, got.last); errors++;
               end
            end
         end
         if (!done && idle_cycles > 200000) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   // sender: bursts with gaps; valid stays high between words of a burst
   int burst_left = 0;
   task automatic send_word(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {2'b00, it.bits, it.row};
      do @(posedge clock); while (!req_tready);
      if (it.op == OP_LOAD)
         adj_rows[it.row] = it.bits;
      else
         predict_coloring();
   endtask

   // wait for all results, then let the block settle before a csr write
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_VERTEX_COUNT: n_reg = val[6:0];
         CSR_COLOR_LIMIT:  k_reg = val[5:0];
         default:          seed_reg = val;
      endcase
      @(posedge clock);
   endtask

   task automatic load_all_rows(input int density);
      req_item_type it;
      for (int r = 0; r < NV; r++) begin
         it.op = OP_LOAD; it.row = 6'(r);
         it.bits = {$urandom, $urandom};
         case (density)
            0: it.bits = '0;
            1: it.bits &= {$urandom, $urandom} & {$urandom, $urandom};
            2: ;
            default: it.bits = '1;
         endcase
         send_word(it);
      end
   endtask

   task automatic run_once();
      req_item_type it;
      it.op = OP_RUN; it.row = 6'($urandom); it.bits = {$urandom, $urandom};
      send_word(it);
   endtask

   // directed rows: a tiny triangle on vertices 0..2, then row 3 gains an edge to vertex 2
   req_item_type directed [] = '{
      '{OP_LOAD, 6'd0, 64'h6},
      '{OP_LOAD, 6'd1, 64'h5},
      '{OP_LOAD, 6'd2, 64'h3},
      '{OP_LOAD, 6'd3, 64'h0},
      '{OP_RUN,  6'd0, 64'h0},
      '{OP_LOAD, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF},
      '{OP_LOAD, 6'd3, 64'h8000_0000_0000_0004},
      '{OP_RUN,  6'd63, 64'hFFFF_FFFF_FFFF_FFFF}
   };

   initial begin
      for (int i = 0; i < NV; i++) adj_rows[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all 64 rows first, so the default n=64 never reads an unwritten row
      load_all_rows(0);
      run_once();                      // empty graph: all color 0
      drain();

      // small graph, k = 1, zero seed: every draw is color 0
      write_csr(CSR_VERTEX_COUNT, 32'd4);
      write_csr(CSR_COLOR_LIMIT, 32'd1);
      write_csr(CSR_RANDOM_SEED, 32'd0);
      foreach (directed[i]) send_word(directed[i]);
      drain();
      write_csr(CSR_COLOR_LIMIT, 32'd2);
      write_csr(CSR_RANDOM_SEED, 32'hFFFF_FFFF);
      run_once();
      drain();
      // out of range values: n=0 -> 1, n=127 -> 64, k=0 -> 1
      write_csr(CSR_VERTEX_COUNT, 32'd0);
      write_csr(CSR_COLOR_LIMIT, 32'd0);
      run_once();
      drain();
      write_csr(CSR_VERTEX_COUNT, 32'h7F);
      write_csr(CSR_COLOR_LIMIT, 32'd63);
      load_all_rows(3);                // complete graph with self loops
      run_once();
      drain();

      // random phases, mostly small graphs
      for (int ph = 0; ph < 16; ph++) begin
         int nn;
         req_item_type it;
         nn = (ph % 6 == 5) ? 64 : $urandom_range(1, 16);
         write_csr(CSR_VERTEX_COUNT, nn);
         write_csr(CSR_COLOR_LIMIT, (ph % 4 == 0) ? 63 : $urandom_range(1, 5));
         write_csr(CSR_RANDOM_SEED, {$urandom});
         for (int r = 0; r < NV; r++) begin
            if (r < nn || $urandom_range(0, 9) == 0) begin
               it.op = OP_LOAD; it.row = 6'(r);
               it.bits = {$urandom, $urandom};
               if (ph % 3 == 1) it.bits &= {$urandom, $urandom};
               send_word(it);
            end
         end
         repeat ($urandom_range(1, 3)) run_once();
         drain();
      end

      done = 1;
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_colors.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end
endmodule

FILE: dsatur_graph_coloring_top.f
+incdir+sv
sv/dsg_pkg.sv
sv/dsatur_graph_coloring_top.sv
sim/testbench.sv
